// ===== design/itoa_pkg.sv =====
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types, character codes and helpers for the integer to ASCII formatter.
// ----------------------------------------------------------------------------
package itoa_pkg;

  // Format opcodes carried with each input beat
  typedef enum logic [2:0] {
    OP_SDEC = 3'd0,
    OP_UDEC = 3'd1,
    OP_LHEX = 3'd2,
    OP_UHEX = 3'd3,
    OP_PTR  = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_SKIP,
    S_EMIT
  } state_t;

  localparam int PointerBitsDefault = 64;

  // Decimal formats work on the low word
  localparam int DecBits   = 32;
  localparam int DecDigits = 10;
  localparam int HexDigits = DecBits / 4;

  localparam int CountBits = 31;
  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

  localparam logic [7:0] ChZero  = 8'd48;
  localparam logic [7:0] ChX     = 8'h78;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [3:0] Ten     = 4'd10;

  // Map one digit to its character; the case flag only matters above nine
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] r;
    if (d < Ten) begin
      r = ChZero + {4'd0, d};
    end else if (upper) begin
      r = ChUpA + {4'd0, d - Ten};
    end else begin
      r = ChLowA + {4'd0, d - Ten};
    end
    return r;
  endfunction

endpackage

// ===== design/itoa_dabble.sv =====
// ----------------------------------------------------------------------------
// itoa_dabble
// Bit-serial binary to BCD converter (shift and add three), one bit per cycle.
// ----------------------------------------------------------------------------
module itoa_dabble
  import itoa_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [DecBits-1:0]     bin,
  output logic                   done,
  output logic [DecDigits*4-1:0] bcd
);

  localparam int CntW = $clog2(DecBits + 1);

  logic [DecBits-1:0]     sr;
  logic [CntW-1:0]        cnt;
  logic                   busy;
  logic [DecDigits*4-1:0] adj;

  // Correct every digit that would overflow on the next doubling
  always_comb begin
    for (int i = 0; i < DecDigits; i++) begin
      adj[i*4 +: 4] = (bcd[i*4 +: 4] >= 4'd5) ? bcd[i*4 +: 4] + 4'd3 : bcd[i*4 +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CntW'(1));
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == CntW'(1))) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sr  <= bin;
      bcd <= '0;
      cnt <= CntW'(DecBits);
    end else if (busy) begin
      sr  <= {sr[DecBits-2:0], 1'b0};
      bcd <= {adj[DecDigits*4-2:0], sr[DecBits-1]};
      cnt <= cnt - CntW'(1);
    end
  end

endmodule

// ===== design/integer_to_ascii_formatter_top.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_top
// Formats one value per input beat as ASCII text, one character per beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries an opcode and a 64-bit value.
//   Output channel (out_valid/out_ready) carries one character per beat,
//   most significant first, with last_char on the final one and the running
//   saturating character total in chars_emitted.
//   One item is worked on at a time. in_ready is high only while the block
//   is idle; the final character may still sit in the output register then.
//   Decimal formats first pass through a bit-serial shift-and-add-three
//   converter, then drop leading zeros one digit per cycle, then one
//   character leaves per cycle while the receiver is ready. Hex and
//   pointer formats skip the converter and drop leading nibbles one per
//   cycle before their characters leave the same way. A stalled receiver
//   holds the output register and adds its stall cycles; no character is
//   lost. Unused opcodes are taken and dropped without output. Reset
//   (rst, synchronous) returns to idle, empties the output register and
//   clears the character count.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_top
  import itoa_pkg::*;
#(
  parameter int POINTER_BITS = PointerBitsDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           opcode,
  input  logic [63:0]          value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           char_out,
  output logic                 last_char,
  output logic [CountBits-1:0] chars_emitted
);

  // Pointer digits, rounded up to whole nibbles
  localparam int PtrNib = (POINTER_BITS + 3) / 4;
  localparam int PtrW   = PtrNib * 4;
  // Digit shifter holds the longest digit string of any format
  localparam int Nib    = (PtrNib > DecDigits) ? PtrNib : DecDigits;
  localparam int DW     = Nib * 4;
  localparam int NdW    = $clog2(Nib + 1);

  state_t                 state, state_next;
  logic [DW-1:0]          dig;
  logic [NdW-1:0]         ndig;
  logic [1:0]             pre_cnt;
  logic                   is_ptr;
  logic                   upper;
  logic [CountBits-1:0]   char_count;

  logic                   accept;
  logic                   emit_go;
  logic                   emit_pre;
  logic                   skip_shift;
  logic                   conv_start;
  logic                   conv_done;
  logic [DecBits-1:0]     lo;
  logic [DecBits-1:0]     conv_bin;
  logic [DecDigits*4-1:0] bcd;
  logic [PtrW-1:0]        ptr;
  logic [3:0]             top_nib;
  logic [7:0]             pre_char;
  opcode_t                op;

  assign op      = opcode_t'(opcode);
  assign lo      = value[DecBits-1:0];
  assign ptr     = PtrW'(value[POINTER_BITS-1:0]);
  assign top_nib = dig[DW-1 -: 4];
  assign accept  = in_valid && in_ready;

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (op) inside
            OP_SDEC, OP_UDEC:         state_next = S_CONV;
            OP_LHEX, OP_UHEX, OP_PTR: state_next = S_SKIP;
            default:                  state_next = S_IDLE;
          endcase
        end
      end
      S_CONV: begin
        if (conv_done) state_next = S_SKIP;
      end
      S_SKIP: begin
        if ((ndig <= NdW'(1)) || (top_nib != 4'd0)) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (emit_go && !emit_pre && (ndig == NdW'(1))) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // ------------------------------------------------------------- control out
  always_comb begin
    in_ready   = (state == S_IDLE);
    // Load the output register when it is empty or being drained this cycle
    emit_go    = (state == S_EMIT) && (!out_valid || out_ready);
    emit_pre   = (pre_cnt != 2'd0);
    skip_shift = (state == S_SKIP) && (state_next == S_SKIP);
    conv_start = accept && ((op == OP_SDEC) || (op == OP_UDEC));
    // Signed decimal converts the magnitude; the minus goes out as a prefix
    conv_bin   = ((op == OP_SDEC) && lo[DecBits-1]) ? (~lo + DecBits'(1)) : lo;
    if (is_ptr) begin
      pre_char = (pre_cnt == 2'd2) ? ChZero : ChX;
    end else begin
      pre_char = ChMinus;
    end
  end

  itoa_dabble u_dabble (
    .clk   (clk),
    .rst   (rst),
    .start (conv_start),
    .bin   (conv_bin),
    .done  (conv_done),
    .bcd   (bcd)
  );

  // ------------------------------------------------------------ control regs
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      char_count <= '0;
    end else begin
      state <= state_next;
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      // Advance the running total, hold at full scale
      if (emit_go && (char_count != CountMax)) begin
        char_count <= char_count + CountBits'(1);
      end
    end
  end

  // Count changes only when a new character is loaded, so it tracks the beat
  assign chars_emitted = char_count;

  // ------------------------------------------------------------ digit path
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && accept) begin
      unique case (op) inside
        OP_SDEC: begin
          is_ptr  <= 1'b0;
          upper   <= 1'b0;
          pre_cnt <= lo[DecBits-1] ? 2'd1 : 2'd0;
        end
        OP_UDEC: begin
          is_ptr  <= 1'b0;
          upper   <= 1'b0;
          pre_cnt <= 2'd0;
        end
        OP_LHEX, OP_UHEX: begin
          is_ptr  <= 1'b0;
          upper   <= (op == OP_UHEX);
          pre_cnt <= 2'd0;
          dig     <= DW'(lo) << (DW - DecBits);
          ndig    <= NdW'(HexDigits);
        end
        OP_PTR: begin
          is_ptr  <= 1'b1;
          upper   <= 1'b0;
          pre_cnt <= 2'd2;
          dig     <= DW'(ptr) << (DW - PtrW);
          ndig    <= NdW'(PtrNib);
        end
        default: begin
          is_ptr  <= 1'b0;
          upper   <= 1'b0;
          pre_cnt <= 2'd0;
        end
      endcase
    end else if ((state == S_CONV) && conv_done) begin
      dig  <= DW'(bcd) << (DW - DecDigits * 4);
      ndig <= NdW'(DecDigits);
    end else if (skip_shift) begin
      // Drop a leading zero, keep at least one digit
      dig  <= dig << 4;
      ndig <= ndig - NdW'(1);
    end else if (emit_go) begin
      if (emit_pre) begin
        char_out  <= pre_char;
        last_char <= 1'b0;
        pre_cnt   <= pre_cnt - 2'd1;
      end else begin
        char_out  <= digit_char(top_nib, upper);
        last_char <= (ndig == NdW'(1));
        dig       <= dig << 4;
        ndig      <= ndig - NdW'(1);
      end
    end
  end

  // ------------------------------------------------------------ assertions
  // A stalled output beat must not move the running total
  a_stall_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(char_count))
    else $error("character count moved during output stall");

  // The final character returns the block to idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (emit_go && !emit_pre && (ndig == NdW'(1))) |=> (state == S_IDLE) && last_char)
    else $error("final character did not close the item");

  // Converter completion only arrives while waiting for it
  a_conv_done: assert property (@(posedge clk) disable iff (rst)
    conv_done |-> (state == S_CONV))
    else $error("converter finished outside conversion");

  // The digit string never runs empty while skipping or emitting
  a_ndig: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SKIP) || (state == S_EMIT)) |-> (ndig != '0))
    else $error("digit count reached zero");

endmodule
